>>> rtl/ptsch_pkg.sv
// Types and constants shared by the thread scheduler.
package ptsch_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_TICK     = 3'd1,
    OP_SCHEDULE = 3'd2,
    OP_SLEEP    = 3'd3,
    OP_WAIT     = 3'd4,
    OP_SIGNAL   = 3'd5,
    OP_KILL     = 3'd6,
    OP_SEM_INIT = 3'd7
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_LAST_KILL = 2'd2,
    ST_NO_READY  = 2'd3
  } status_e;

  localparam logic [7:0]  PrioNone  = 8'd255;
  localparam logic [31:0] SleepDead = 32'hFFFF_FFFF;
  localparam logic signed [15:0] SemMin = -16'sd32768;
  localparam logic signed [15:0] SemMax = 16'sd32767;

  // Input word
  typedef struct packed {
    op_e                op;
    logic [7:0]         priority_req;
    logic [31:0]        sleep_time;
    logic [2:0]         sem_index;
    logic signed [15:0] initial_value;
  } in_t;

  // Result word
  typedef struct packed {
    status_e            status;
    logic [4:0]         running_slot;
    logic [15:0]        running_id;
    logic [5:0]         thread_count;
    logic signed [15:0] sem_value;
  } out_t;

endpackage

>>> rtl/priority_thread_scheduler.sv
// Priority round-robin thread scheduler with a semaphore bank, one op per word.
//
// One op is taken at a time; in_ready_o is low from acceptance until the result
// word has been taken. All thread-table reads go through a single read index that
// a small sequencer steps one slot per cycle. After dispatch, each op walks the table
// as follows before the result word is built: sleep, wait and semaphore init need
// no walk; tick sweeps every slot; schedule and signal scan the ring; add does a
// lowest-free-slot sweep, then a predecessor walk; kill does a ring scan, then a
// predecessor walk. The result is held in an output register until taken; the
// next op can be accepted in the cycle after that.
// No clearing pass is needed after reset.
module priority_thread_scheduler import ptsch_pkg::*; #(
  parameter int MAX_THREADS    = 32,
  parameter int NUM_SEMAPHORES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int SlotW = $clog2(MAX_THREADS);
  localparam int CntW  = $clog2(MAX_THREADS + 1);
  localparam int SemW  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(MAX_THREADS - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_FREE  = 9'b000000100,
    S_PRED  = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_TICK  = 9'b000100000,
    S_LINK  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // Thread table and semaphores
  logic [15:0]       id_q    [MAX_THREADS];
  logic [7:0]        prio_q  [MAX_THREADS];
  logic              blk_q   [MAX_THREADS];
  logic [2:0]        bsem_q  [MAX_THREADS];
  logic [31:0]       sleep_q [MAX_THREADS];
  logic [SlotW-1:0]  next_q  [MAX_THREADS];
  logic signed [15:0] sem_q  [NUM_SEMAPHORES];

  logic [SlotW-1:0] run_q, run_d;
  logic [CntW-1:0]  live_q, live_d;
  logic [15:0]      idc_q, idc_d;

  // Latched input word and walk registers
  in_t              in_q;
  logic [SlotW-1:0] ptr_q, ptr_d;
  logic [SlotW-1:0] new_q, new_d;
  logic [SlotW-1:0] victim_q, victim_d;
  logic [SlotW-1:0] after_q, after_d;
  logic [SlotW-1:0] best_q, best_d;
  logic [7:0]       top_q, top_d;
  logic             found_q, found_d;
  status_e          status_q, status_d;

  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  // Table read port
  logic [SlotW-1:0] rd_idx;
  logic [15:0]      rd_id;
  logic [7:0]       rd_prio;
  logic             rd_blk;
  logic [2:0]       rd_bsem;
  logic [31:0]      rd_sleep;
  logic [SlotW-1:0] rd_next;

  // Table write controls
  logic             id_we, blk_we, bsem_we, slp_we, nxt_we, prio_we, sem_we;
  logic [SlotW-1:0] id_wa, blk_wa, bsem_wa, slp_wa, nxt_wa;
  logic [15:0]      id_wd;
  logic             blk_wd;
  logic [2:0]       bsem_wd;
  logic [31:0]      slp_wd;
  logic [SlotW-1:0] nxt_wd;
  logic signed [15:0] sem_wd;

  // Semaphore access
  logic               sem_ok;
  logic [SemW-1:0]    sem_idx;
  logic signed [15:0] sem_cur, sem_dec, sem_inc;

  // Scan helpers
  logic             cand;
  logic [7:0]       top_n;
  logic [SlotW-1:0] best_n;
  logic             found_n;
  logic [SlotW-1:0] pred_tgt;
  logic [15:0]      idc_n;
  logic             accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rd_idx   = ((state_q == S_DISP) || (state_q == S_DONE)) ? run_q : ptr_q;
  assign rd_id    = id_q[rd_idx];
  assign rd_prio  = prio_q[rd_idx];
  assign rd_blk   = blk_q[rd_idx];
  assign rd_bsem  = bsem_q[rd_idx];
  assign rd_sleep = sleep_q[rd_idx];
  assign rd_next  = next_q[rd_idx];

  assign sem_ok  = int'(in_q.sem_index) < NUM_SEMAPHORES;
  assign sem_idx = SemW'(in_q.sem_index);
  assign sem_cur = sem_q[sem_idx];
  assign sem_dec = (sem_cur > SemMin) ? sem_cur - 16'sd1 : sem_cur;
  assign sem_inc = (sem_cur < SemMax) ? sem_cur + 16'sd1 : sem_cur;

  // Best-candidate update for the current ring entry
  assign cand    = !rd_blk && (rd_sleep == '0) && (rd_prio < top_q);
  assign top_n   = cand ? rd_prio : top_q;
  assign best_n  = cand ? ptr_q : best_q;
  assign found_n = cand || found_q;

  assign pred_tgt = (in_q.op == OP_ADD) ? run_q : victim_q;
  assign idc_n    = (idc_q == 16'hFFFF) ? 16'd1 : idc_q + 16'd1;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    run_d       = run_q;
    live_d      = live_q;
    idc_d       = idc_q;
    ptr_d       = ptr_q;
    new_d       = new_q;
    victim_d    = victim_q;
    after_d     = after_q;
    best_d      = best_q;
    top_d       = top_q;
    found_d     = found_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    id_we = 1'b0;  id_wa = rd_idx; id_wd = '0;
    blk_we = 1'b0; blk_wa = rd_idx; blk_wd = 1'b0;
    bsem_we = 1'b0; bsem_wa = rd_idx; bsem_wd = '0;
    slp_we = 1'b0; slp_wa = rd_idx; slp_wd = '0;
    nxt_we = 1'b0; nxt_wa = rd_idx; nxt_wd = rd_idx;
    prio_we = 1'b0;
    sem_we = 1'b0; sem_wd = sem_cur;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_OK;
          state_d  = S_DISP;
        end
      end

      S_DISP: begin
        state_d  = S_DONE;
        victim_d = run_q;
        top_d    = PrioNone;
        found_d  = 1'b0;
        case (in_q.op)
          OP_ADD: begin
            ptr_d   = '0;
            state_d = S_FREE;
          end
          OP_TICK: begin
            ptr_d   = '0;
            state_d = S_TICK;
          end
          OP_SCHEDULE: begin
            if (live_q == '0) begin
              status_d = ST_NO_READY;
            end else begin
              ptr_d   = rd_next;
              state_d = S_SCAN;
            end
          end
          OP_SLEEP: begin
            if (live_q != '0) begin
              slp_we = 1'b1;
              slp_wd = in_q.sleep_time;
            end
          end
          OP_WAIT: begin
            if (sem_ok) begin
              sem_we = 1'b1;
              sem_wd = sem_dec;
              if ((sem_dec < 16'sd0) && (live_q != '0)) begin
                blk_we  = 1'b1;
                blk_wd  = 1'b1;
                bsem_we = 1'b1;
                bsem_wd = in_q.sem_index;
              end
            end
          end
          OP_SIGNAL: begin
            if (sem_ok) begin
              sem_we = 1'b1;
              sem_wd = sem_inc;
              if ((sem_inc <= 16'sd0) && (live_q != '0)) begin
                ptr_d   = rd_next;
                state_d = S_SCAN;
              end
            end
          end
          OP_KILL: begin
            if (live_q <= CntW'(1)) begin
              status_d = ST_LAST_KILL;
            end else begin
              live_d  = live_q - CntW'(1);
              slp_we  = 1'b1;
              slp_wd  = SleepDead;
              after_d = rd_next;
              ptr_d   = rd_next;
              state_d = S_SCAN;
            end
          end
          default: begin
            if (sem_ok) begin
              sem_we = 1'b1;
              sem_wd = in_q.initial_value;
            end
          end
        endcase
      end

      // Lowest free slot sweep
      S_FREE: begin
        if (rd_id == '0) begin
          new_d  = ptr_q;
          nxt_we = 1'b1;
          if (live_q == '0) begin
            run_d   = ptr_q;
            nxt_wd  = ptr_q;
            state_d = S_WRITE;
          end else begin
            nxt_wd  = run_q;
            ptr_d   = run_q;
            state_d = S_PRED;
          end
        end else if (ptr_q == LastSlot) begin
          status_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          ptr_d = ptr_q + SlotW'(1);
        end
      end

      // Predecessor walk around the ring
      S_PRED: begin
        if (rd_next == pred_tgt) begin
          state_d = S_LINK;
        end else begin
          ptr_d = rd_next;
        end
      end

      S_LINK: begin
        nxt_we = 1'b1;
        if (in_q.op == OP_ADD) begin
          nxt_wd  = new_q;
          state_d = S_WRITE;
        end else begin
          nxt_wd  = after_q;
          state_d = S_DONE;
        end
      end

      // Fill the new thread's slot
      S_WRITE: begin
        id_we   = 1'b1; id_wa = new_q; id_wd = idc_n;
        prio_we = 1'b1;
        blk_we  = 1'b1; blk_wa = new_q; blk_wd = 1'b0;
        bsem_we = 1'b1; bsem_wa = new_q; bsem_wd = '0;
        slp_we  = 1'b1; slp_wa = new_q; slp_wd = '0;
        idc_d   = idc_n;
        live_d  = live_q + CntW'(1);
        state_d = S_DONE;
      end

      // Ring scan after the running thread, the running thread last
      S_SCAN: begin
        if (in_q.op == OP_SIGNAL) begin
          if (rd_blk && (rd_bsem == in_q.sem_index)) begin
            blk_we  = 1'b1;
            blk_wd  = 1'b0;
            state_d = S_DONE;
          end else if (ptr_q == victim_q) begin
            state_d = S_DONE;
          end else begin
            ptr_d = rd_next;
          end
        end else begin
          top_d   = top_n;
          best_d  = best_n;
          found_d = found_n;
          if (ptr_q == victim_q) begin
            if (!found_n) status_d = ST_NO_READY;
            if (in_q.op == OP_KILL) begin
              run_d   = found_n ? best_n : after_q;
              id_we   = 1'b1;
              id_wa   = victim_q;
              id_wd   = '0;
              ptr_d   = victim_q;
              state_d = S_PRED;
            end else begin
              if (found_n) run_d = best_n;
              state_d = S_DONE;
            end
          end else begin
            ptr_d = rd_next;
          end
        end
      end

      // Sleep counter sweep
      S_TICK: begin
        if (rd_sleep != '0) begin
          slp_we = 1'b1;
          slp_wd = rd_sleep - 32'd1;
        end
        if (ptr_q == LastSlot) begin
          state_d = S_DONE;
        end else begin
          ptr_d = ptr_q + SlotW'(1);
        end
      end

      // Build the result word
      S_DONE: begin
        out_d.status       = status_q;
        out_d.running_slot = 5'(run_q);
        out_d.running_id   = (live_q != '0) ? rd_id : 16'd0;
        out_d.thread_count = 6'(live_q);
        out_d.sem_value    = sem_ok ? sem_cur : 16'sd0;
        out_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_q       <= '0;
      live_q      <= '0;
      idc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_q       <= run_d;
      live_q      <= live_d;
      idc_q       <= idc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    ptr_q    <= ptr_d;
    new_q    <= new_d;
    victim_q <= victim_d;
    after_q  <= after_d;
    best_q   <= best_d;
    top_q    <= top_d;
    found_q  <= found_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  // Table stores with a defined reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        id_q[i]    <= '0;
        blk_q[i]   <= 1'b0;
        sleep_q[i] <= '0;
      end
      for (int s = 0; s < NUM_SEMAPHORES; s++) begin
        sem_q[s] <= '0;
      end
    end else begin
      if (id_we)  id_q[id_wa]     <= id_wd;
      if (blk_we) blk_q[blk_wa]   <= blk_wd;
      if (slp_we) sleep_q[slp_wa] <= slp_wd;
      if (sem_we) sem_q[sem_idx]  <= sem_wd;
    end
  end

  // Table stores left undefined until written
  always_ff @(posedge clk_i) begin
    if (prio_we) prio_q[new_q]   <= in_q.priority_req;
    if (bsem_we) bsem_q[bsem_wa] <= bsem_wd;
    if (nxt_we)  next_q[nxt_wa]  <= nxt_wd;
  end

  // Checks
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(live_q) <= MAX_THREADS)
    else $error("live thread count above table size");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result word raised outside result build");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("ready while an op is in flight");

  a_signal_keeps_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && in_q.op == OP_SIGNAL) |=> $stable(live_q) && $stable(run_q))
    else $error("signal scan changed thread count or running slot");

endmodule
